// ----- hw/rtl/hsic_pkg.sv -----
// ----------------------------------------------------------------------------
// hsic_pkg
// Shared types and constants for the hexagonal spiral index to coordinate core.
// ----------------------------------------------------------------------------
package hsic_pkg;

    localparam int IDX_W        = 18;
    localparam int COORD_W      = 10;
    localparam int CALC_W       = COORD_W + 1;
    localparam int MAX_RING_DEF = 255;
    localparam int RING_STEP    = 6;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RING,
        ST_SIDE,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        SIDE_E,
        SIDE_NE,
        SIDE_NW,
        SIDE_W,
        SIDE_SW,
        SIDE_SE
    } side_t;

    typedef struct packed {
        logic [IDX_W-1:0] diff;
        logic             borrow;
    } sub_res_t;

endpackage

// ----- hw/rtl/hsic_if.sv -----
// ----------------------------------------------------------------------------
// hsic_in_if / hsic_out_if
// Valid/ready channels carrying the cell index request and the coordinates.
// ----------------------------------------------------------------------------
interface hsic_in_if;
    logic                        valid;
    logic                        ready;
    logic [hsic_pkg::IDX_W-1:0]  cell_index;

    modport source (output valid, output cell_index, input ready);
    modport sink   (input valid, input cell_index, output ready);
endinterface

interface hsic_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [hsic_pkg::COORD_W-1:0] pos_x;
    logic signed [hsic_pkg::COORD_W-1:0] pos_y;
    logic                               out_of_range;

    modport source (output valid, output pos_x, output pos_y, output out_of_range,
                    input ready);
    modport sink   (input valid, input pos_x, input pos_y, input out_of_range,
                    output ready);
endinterface

// ----- hw/rtl/hsic_sub_unit.sv -----
// ----------------------------------------------------------------------------
// hsic_sub_unit
// Shared subtractor: difference of two operands and the borrow out.
// ----------------------------------------------------------------------------
module hsic_sub_unit (
    input  logic [hsic_pkg::IDX_W-1:0] a,
    input  logic [hsic_pkg::IDX_W-1:0] b,
    output hsic_pkg::sub_res_t         res
);

    logic [hsic_pkg::IDX_W:0] full;

    assign full       = {1'b0, a} - {1'b0, b};
    assign res.diff   = full[hsic_pkg::IDX_W-1:0];
    assign res.borrow = full[hsic_pkg::IDX_W];

endmodule

// ----- hw/rtl/hex_spiral_index_to_coord_core.sv -----
// ----------------------------------------------------------------------------
// hex_spiral_index_to_coord_core
// Maps a spiral cell index to doubled hex coordinates with one shared
// subtractor under a small sequencer.
// ----------------------------------------------------------------------------
//  channel  dir  payload                          handshake
//  in_ch    in   cell_index[17:0]                 valid/ready
//  out_ch   out  pos_x[9:0] pos_y[9:0] out_of_range valid/ready
//
//  Sequence: the ring search subtracts 6r once a cycle from the remaining
//  index, r the ring reached (up to MAX_RING); the side search then
//  subtracts r to find the side number (0..5). Index 0 goes straight to
//  the final state; an index beyond the last ring stops the ring search at
//  MAX_RING and is flagged out of range.
//  Reset clears the sequencer and the output valid flag.
//  A new request is taken while the previous result waits in the output
//  register; a stalled output holds the sequencer in its final state.
// ----------------------------------------------------------------------------
module hex_spiral_index_to_coord_core #(
    parameter int MAX_RING = hsic_pkg::MAX_RING_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    hsic_in_if.sink      in_ch,
    hsic_out_if.source   out_ch
);

    localparam int IW     = hsic_pkg::IDX_W;
    localparam int CW     = hsic_pkg::CALC_W;
    localparam int OW     = hsic_pkg::COORD_W;
    localparam int RING_W = $clog2(MAX_RING + 1);
    localparam int STEP_W = $clog2(hsic_pkg::RING_STEP * MAX_RING + 1);

    hsic_pkg::state_t   state_reg, state_next;
    hsic_pkg::side_t    side_reg, side_next;
    logic [RING_W-1:0]  ring_reg, ring_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [IW-1:0]      rem_reg, rem_next;
    logic               oor_reg, oor_next;

    logic                 out_valid_reg, out_valid_next;
    logic signed [OW-1:0] pos_x_reg, pos_y_reg;
    logic                 oor_out_reg;

    logic [IW-1:0]       sub_b;
    hsic_pkg::sub_res_t  sub_res;
    logic                load_out;

    logic signed [CW-1:0] rs, ts, rs2, ts2, cx, cy;

    hsic_sub_unit u_sub (
        .a   (rem_reg),
        .b   (sub_b),
        .res (sub_res)
    );

    always_comb
    begin
        if (state_reg == hsic_pkg::ST_SIDE)
        begin
            sub_b = IW'(ring_reg);
        end
        else
        begin
            sub_b = IW'(step_reg);
        end
    end

    assign load_out    = (state_reg == hsic_pkg::ST_DONE) && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = (state_reg == hsic_pkg::ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        side_next  = side_reg;
        ring_next  = ring_reg;
        step_next  = step_reg;
        rem_next   = rem_reg;
        oor_next   = oor_reg;
        unique case (state_reg)
            hsic_pkg::ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    side_next = hsic_pkg::SIDE_E;
                    oor_next  = 1'b0;
                    ring_next = RING_W'(1);
                    step_next = STEP_W'(hsic_pkg::RING_STEP);
                    if (in_ch.cell_index == '0)
                    begin
                        // centre: zero ring gives zero coordinates
                        ring_next  = '0;
                        rem_next   = '0;
                        state_next = hsic_pkg::ST_DONE;
                    end
                    else
                    begin
                        rem_next   = in_ch.cell_index - IW'(1);
                        state_next = hsic_pkg::ST_RING;
                    end
                end
            end
            hsic_pkg::ST_RING:
            begin
                if (sub_res.borrow)
                begin
                    // remainder is now the offset within this ring
                    state_next = hsic_pkg::ST_SIDE;
                end
                else if (ring_reg == RING_W'(MAX_RING))
                begin
                    oor_next   = 1'b1;
                    ring_next  = '0;
                    rem_next   = '0;
                    state_next = hsic_pkg::ST_DONE;
                end
                else
                begin
                    rem_next  = sub_res.diff;
                    ring_next = ring_reg + RING_W'(1);
                    step_next = step_reg + STEP_W'(hsic_pkg::RING_STEP);
                end
            end
            hsic_pkg::ST_SIDE:
            begin
                if (sub_res.borrow)
                begin
                    state_next = hsic_pkg::ST_DONE;
                end
                else
                begin
                    rem_next  = sub_res.diff;
                    side_next = hsic_pkg::side_t'(side_reg + 3'd1);
                end
            end
            hsic_pkg::ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = hsic_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hsic_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hsic_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg <= side_next;
        ring_reg <= ring_next;
        step_reg <= step_next;
        rem_reg  <= rem_next;
        oor_reg  <= oor_next;
    end

    // corner of the side plus offset along it
    assign rs  = $signed(CW'(ring_reg));
    assign ts  = $signed(CW'(rem_reg[RING_W-1:0]));
    assign rs2 = rs <<< 1;
    assign ts2 = ts <<< 1;

    always_comb
    begin
        unique case (side_reg)
            hsic_pkg::SIDE_E:  begin cx = ts2 - rs;  cy = -rs2;      end
            hsic_pkg::SIDE_NE: begin cx = rs + ts;   cy = ts2 - rs2; end
            hsic_pkg::SIDE_NW: begin cx = rs2 - ts;  cy = ts2;       end
            hsic_pkg::SIDE_W:  begin cx = rs - ts2;  cy = rs2;       end
            hsic_pkg::SIDE_SW: begin cx = -rs - ts;  cy = rs2 - ts2; end
            hsic_pkg::SIDE_SE: begin cx = ts - rs2;  cy = -ts2;      end
            default:           begin cx = '0;        cy = '0;        end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            pos_x_reg   <= cx[OW-1:0];
            pos_y_reg   <= cy[OW-1:0];
            oor_out_reg <= oor_reg;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.pos_x        = pos_x_reg;
    assign out_ch.pos_y        = pos_y_reg;
    assign out_ch.out_of_range = oor_out_reg;

    a_ring_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hsic_pkg::ST_RING && sub_res.borrow) |=> state_reg == hsic_pkg::ST_SIDE)
        else $error("ring search did not hand over to side search");

    a_side_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hsic_pkg::ST_SIDE && side_reg == hsic_pkg::SIDE_SE) |-> sub_res.borrow)
        else $error("offset exceeds the last side of the ring");

    a_side_ring: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == hsic_pkg::ST_SIDE |-> ring_reg != '0)
        else $error("side search with zero ring");

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && oor_out_reg) |-> (pos_x_reg == '0 && pos_y_reg == '0))
        else $error("out of range result with nonzero coordinates");

    a_load_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == hsic_pkg::ST_DONE)
        else $error("result loaded outside the final state");

endmodule

// ----- sim/hex_spiral_index_to_coord_core_tb.sv -----
// ----------------------------------------------------------------------------
// hex_spiral_index_to_coord_core_tb
// Drives spiral cell indices into the core and checks every coordinate result
// against an in-bench model of the hexagonal spiral walk. Both channels idle
// in random bursts; one long output hold-off backs the core up into its input.
// ----------------------------------------------------------------------------
module hex_spiral_index_to_coord_core_tb;

    localparam int IDX_W          = hsic_pkg::IDX_W;
    localparam int COORD_W        = hsic_pkg::COORD_W;
    localparam int MAX_RING       = hsic_pkg::MAX_RING_DEF;
    localparam int LAST_CELL      = 3 * MAX_RING * (MAX_RING + 1);
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 300;

    typedef logic [IDX_W-1:0] cell_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      oor;
    } hex_coord_t;

    logic clk;
    logic rst_n;

    hsic_in_if  in_ch ();
    hsic_out_if out_ch ();

    hex_spiral_index_to_coord_core #(
        .MAX_RING (MAX_RING)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    cell_t      pending_indices[$];
    hex_coord_t expected_coords[$];

    int   errors = 0;
    int   src_gap_pct;
    int   sink_stall_pct;
    int   src_gap_left;
    int   sink_stall_left;
    int   hold_left;
    int   holds_asked;
    int   holds_done = 0;
    int   quiet_cycles = 0;
    logic in_taken;

    always #5 clk = ~clk;

    // Find the ring by search, then the side and the offset along that side.
    function automatic hex_coord_t spiral_coord(cell_t idx);
        hex_coord_t c;
        int ring;
        int k;
        int t;
        int cx;
        int cy;
        int sx;
        int sy;
        hsic_pkg::side_t side;
        c = '0;
        ring = 0;
        if (idx != 0) begin
            for (int r = 1; r <= MAX_RING; r++) begin
                if (ring == 0 && 3 * r * (r + 1) >= int'(idx))
                    ring = r;
            end
            if (ring == 0) begin
                c.oor = 1'b1;
            end
            else begin
                k = int'(idx) - 1 - 3 * ring * (ring - 1);
                t = k % ring;
                side = (k / ring > 5) ? hsic_pkg::SIDE_SE : hsic_pkg::side_t'(k / ring);
                case (side)
                    hsic_pkg::SIDE_E:  begin cx = -1; cy = -2; sx =  2; sy =  0; end
                    hsic_pkg::SIDE_NE: begin cx =  1; cy = -2; sx =  1; sy =  2; end
                    hsic_pkg::SIDE_NW: begin cx =  2; cy =  0; sx = -1; sy =  2; end
                    hsic_pkg::SIDE_W:  begin cx =  1; cy =  2; sx = -2; sy =  0; end
                    hsic_pkg::SIDE_SW: begin cx = -1; cy =  2; sx = -1; sy = -2; end
                    default:           begin cx = -2; cy =  0; sx =  1; sy = -2; end
                endcase
                c.x = COORD_W'(cx * ring + sx * t);
                c.y = COORD_W'(cy * ring + sy * t);
            end
        end
        return c;
    endfunction

    // Mostly in-range cells, most on small rings, some on deep rings; beyond-range and raw indices.
    task automatic queue_random(input int count);
        int pick;
        int r;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 19);
            if (pick < 12) begin
                r = (pick < 9) ? $urandom_range(1, 16) : $urandom_range(1, MAX_RING);
                pending_indices.insert(pending_indices.size(),
                                       cell_t'(3 * r * (r - 1) + 1
                                               + $urandom_range(0, 6 * r - 1)));
            end
            else if (pick < 15) begin
                pending_indices.insert(pending_indices.size(),
                                       cell_t'($urandom_range(LAST_CELL + 1,
                                                              2**IDX_W - 1)));
            end
            else begin
                pending_indices.insert(pending_indices.size(),
                                       cell_t'($urandom_range(0, 2**IDX_W - 1)));
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_indices.size() != 0 || expected_coords.size() != 0)
            @(posedge clk);
    endtask

    // Request driver: hold a request until taken, then advance or idle.
    always @(negedge clk) begin
        if (!rst_n) begin
            in_ch.valid      <= 1'b0;
            in_ch.cell_index <= '0;
            src_gap_left = 0;
        end
        else if (!(in_ch.valid && !in_taken)) begin
            if (in_taken)
                void'(pending_indices.pop_front());
            if (src_gap_left > 0) begin
                src_gap_left--;
                in_ch.valid <= 1'b0;
            end
            else if (pending_indices.size() == 0) begin
                in_ch.valid <= 1'b0;
            end
            else if ($urandom_range(0, 99) < src_gap_pct) begin
                src_gap_left = $urandom_range(0, 16);
                in_ch.valid <= 1'b0;
            end
            else begin
                in_ch.valid      <= 1'b1;
                in_ch.cell_index <= pending_indices[0];
            end
        end
    end

    // Result receiver: random stall bursts plus the long hold-off on request.
    always @(negedge clk) begin
        if (!rst_n) begin
            out_ch.ready    <= 1'b0;
            sink_stall_left = 0;
            hold_left       = 0;
        end
        else if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end
        else if (holds_done < holds_asked) begin
            holds_done++;
            hold_left = HOLD_CYCLES - 1;
            out_ch.ready <= 1'b0;
        end
        else if (sink_stall_left > 0) begin
            sink_stall_left--;
            out_ch.ready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < sink_stall_pct) begin
            sink_stall_left = $urandom_range(0, 16);
            out_ch.ready <= 1'b0;
        end
        else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Monitor: predict on each accepted request, check each accepted result.
    always @(posedge clk) begin
        hex_coord_t want;
        if (!rst_n) begin
            in_taken <= 1'b0;
        end
        else begin
            in_taken <= in_ch.valid && in_ch.ready;
            if (in_ch.valid && in_ch.ready)
                expected_coords.insert(expected_coords.size(),
                                       spiral_coord(in_ch.cell_index));
            if (out_ch.valid && out_ch.ready) begin
                if (expected_coords.size() == 0) begin
                    $error("unexpected result: pos_x %0d pos_y %0d out_of_range %0b",
                           out_ch.pos_x, out_ch.pos_y, out_ch.out_of_range);
                    errors++;
                end
                else begin
                    want = expected_coords.pop_front();
                    if (out_ch.pos_x !== want.x) begin
                        $error("pos_x: expected %0d, got %0d", want.x, out_ch.pos_x);
                        errors++;
                    end
                    if (out_ch.pos_y !== want.y) begin
                        $error("pos_y: expected %0d, got %0d", want.y, out_ch.pos_y);
                        errors++;
                    end
                    if (out_ch.out_of_range !== want.oor) begin
                        $error("out_of_range: expected %0b, got %0b",
                               want.oor, out_ch.out_of_range);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("hex_spiral_index_to_coord_core_tb failed");
            $finish;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        src_gap_pct      = 0;
        sink_stall_pct   = 0;
        holds_asked      = 0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Centre, every side of ring one, ring edges, last ring, beyond range.
        pending_indices = '{
            cell_t'(0), cell_t'(1), cell_t'(2), cell_t'(3), cell_t'(4), cell_t'(5),
            cell_t'(6), cell_t'(7), cell_t'(12), cell_t'(18), cell_t'(19), cell_t'(37),
            cell_t'(3 * MAX_RING * (MAX_RING - 1) + 1),
            cell_t'(3 * MAX_RING * (MAX_RING - 1) + 1 + MAX_RING),
            cell_t'(3 * MAX_RING * (MAX_RING - 1) + 5 * MAX_RING + 1),
            cell_t'(LAST_CELL), cell_t'(LAST_CELL + 1),
            cell_t'(65535), cell_t'(131072), cell_t'(2**IDX_W - 1)
        };
        src_gap_pct    = 15;
        sink_stall_pct = 15;
        wait_drained();

        src_gap_pct    = 20;
        sink_stall_pct = 20;
        queue_random(200);
        holds_asked = 1;
        wait_drained();

        src_gap_pct    = 0;
        sink_stall_pct = 0;
        queue_random(100);
        wait_drained();

        src_gap_pct    = 40;
        sink_stall_pct = 40;
        queue_random(120);
        wait_drained();

        src_gap_pct    = 0;
        sink_stall_pct = 0;
        queue_random(80);
        wait_drained();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("hex_spiral_index_to_coord_core_tb passed");
        else
            $display("hex_spiral_index_to_coord_core_tb failed");
        $finish;
    end

endmodule
